// File: rtl/aes_pkg.sv
// AES-256 engine package: widths, S-box functions, GF helpers and round transforms.
// Depends on nothing; used by every module of the engine.
package aes_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int KEY_BITS    = 256;
   localparam int KEY_WORDS   = KEY_BITS / 32;
   localparam int ROUNDS      = KEY_WORDS + 6;
   localparam int RK_ENTRIES  = 2 * (ROUNDS + 1);
   localparam int RK_AW       = $clog2(RK_ENTRIES);
   localparam int RND_W       = $clog2(ROUNDS + 1);
   localparam int CNT_W       = 5;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;
   localparam logic [1:0] CSR_KEY3 = 2'd3;

   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits 127-8i
   function automatic logic [7:0] get_b(input block_type s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

   function automatic block_type fwd_round(input block_type s, input logic last_rnd);
      block_type t;
      block_type m;
      logic [7:0] a0, a1, a2, a3;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[127 - 8*(r + 4*c) -: 8] = sbox(get_b(s, r + 4*((c + r) & 3)));
      m = t;
      for (int c = 0; c < 4; c++) begin
         a0 = get_b(t, 4*c);     a1 = get_b(t, 4*c + 1);
         a2 = get_b(t, 4*c + 2); a3 = get_b(t, 4*c + 3);
         m[127 - 32*c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         m[119 - 32*c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         m[111 - 32*c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         m[103 - 32*c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      return last_rnd ? t : m;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = inv_sbox(get_b(s, r + 4*c));
      return t;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type m;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] k9 [4];
      logic [7:0] kb [4];
      logic [7:0] kd [4];
      logic [7:0] ke [4];
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j]  = get_b(s, 4*c + j);
            x2[j] = xt(a[j]);
            x4[j] = xt(x2[j]);
            x8[j] = xt(x4[j]);
            k9[j] = x8[j] ^ a[j];
            kb[j] = x8[j] ^ x2[j] ^ a[j];
            kd[j] = x8[j] ^ x4[j] ^ a[j];
            ke[j] = x8[j] ^ x4[j] ^ x2[j];
         end
         m[127 - 32*c -: 8] = ke[0] ^ kb[1] ^ kd[2] ^ k9[3];
         m[119 - 32*c -: 8] = k9[0] ^ ke[1] ^ kb[2] ^ kd[3];
         m[111 - 32*c -: 8] = kd[0] ^ k9[1] ^ ke[2] ^ kb[3];
         m[103 - 32*c -: 8] = kb[0] ^ kd[1] ^ k9[2] ^ ke[3];
      end
      return m;
   endfunction

endpackage

// File: rtl/aes_key_sched.sv
// AES-256 key expansion: one 32-bit schedule word per cycle into the round key memory.
// Depends on aes_pkg.
module aes_key_sched (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [255:0]              key,
   input  logic [aes_pkg::RK_AW-1:0] rd_addr,
   output logic [127:0]              rd_data,
   output logic                      busy
);
   import aes_pkg::*;

   localparam int SCHED_WORDS = 4 * (ROUNDS + 1);
   localparam int WI_W = $clog2(SCHED_WORDS + 1);

   // round key memory: two 64-bit halves per round key row
   logic [127:0] rk_mem [ROUNDS + 1];
   logic [31:0]  win_ff [KEY_WORDS];
   logic [31:0]  win_in [KEY_WORDS];
   logic [WI_W-1:0] idx_ff, idx_in;
   logic         busy_ff, busy_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  t, new_w;
   logic [2:0]   pos;
   logic [127:0] row_ff, row_in;

   assign pos = idx_ff[2:0];

   always_comb begin
      t = win_ff[KEY_WORDS-1];
      if (pos == 3'd0)
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      else if (pos == 3'd4)
         t = sub_word(t);
      new_w = win_ff[0] ^ t;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      rcon_in = rcon_ff;
      win_in  = win_ff;
      row_in  = row_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = WI_W'(KEY_WORDS);
         rcon_in = 8'h01;
         for (int i = 0; i < KEY_WORDS; i++)
            win_in[i] = key[255 - 32*i -: 32];
      end else if (busy_ff) begin
         for (int i = 0; i < KEY_WORDS - 1; i++)
            win_in[i] = win_ff[i+1];
         win_in[KEY_WORDS-1] = new_w;
         row_in = {row_ff[95:0], new_w};
         if (pos == 3'd0)
            rcon_in = xt(rcon_ff);
         idx_in = idx_ff + 1'b1;
         if (idx_ff == WI_W'(SCHED_WORDS - 1))
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         rcon_ff <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         rcon_ff <= rcon_in;
      end
      win_ff <= win_in;
      row_ff <= row_in;
   end

   // key rows 0 and 1 are the raw key; later rows fill as each fourth word lands
   logic [RND_W-1:0] wr_row;
   logic             wr_en;
   logic [127:0]     wr_data;
   always_comb begin
      wr_en   = 1'b0;
      wr_row  = '0;
      wr_data = {row_ff[95:0], new_w};
      if (start) begin
         wr_en = 1'b0;
      end else if (busy_ff && idx_ff[1:0] == 2'd3) begin
         wr_en  = 1'b1;
         wr_row = idx_ff[WI_W-1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rk_mem[0] <= key[255:128];
      end else if (wr_en) begin
         rk_mem[wr_row] <= wr_data;
      end
   end

   logic [127:0] key1_ff;
   always_ff @(posedge clock) begin
      if (start)
         key1_ff <= key[127:0];
   end

   logic [127:0] rd_mem_ff;
   logic         rd_is1_ff;
   always_ff @(posedge clock) begin
      rd_mem_ff <= rk_mem[rd_addr[RK_AW-1:1]];
      rd_is1_ff <= (rd_addr[RK_AW-1:1] == RND_W'(1));
   end
   assign rd_data = rd_is1_ff ? key1_ff : rd_mem_ff;
   assign busy    = busy_ff;

   property p_busy_len;
      @(posedge clock) disable iff (reset)
         start |=> busy_ff && idx_ff == WI_W'(KEY_WORDS);
   endproperty
   a_busy_len: assert property (p_busy_len) else $error("schedule start");

   property p_idx_range;
      @(posedge clock) disable iff (reset)
         busy_ff |-> idx_ff < WI_W'(SCHED_WORDS);
   endproperty
   a_idx_range: assert property (p_idx_range) else $error("schedule index");

   property p_done;
      @(posedge clock) disable iff (reset)
         busy_ff && !start && idx_ff == WI_W'(SCHED_WORDS - 1) |=> !busy_ff;
   endproperty
   a_done: assert property (p_done) else $error("schedule end");
endmodule

// File: rtl/aes_round_unit.sv
// Shared AES round datapath on a state register: key add or one enc/dec round per cycle while step is high.
// Depends on aes_pkg.
module aes_round_unit (
   input  logic                  clock,
   input  logic                  load,
   input  logic                  step,
   input  logic                  decrypt,
   input  logic                  first,
   input  logic                  final_rnd,
   input  aes_pkg::block_type    din,
   input  aes_pkg::block_type    round_key,
   output aes_pkg::block_type    state
);
   import aes_pkg::*;

   block_type st_ff, st_in, enc_r, dec_a;

   always_comb begin
      enc_r = fwd_round(st_ff, final_rnd) ^ round_key;
      dec_a = inv_shift_sub(st_ff) ^ round_key;
      priority if (load)
         st_in = din;
      else if (step && first)
         st_in = st_ff ^ round_key;
      else if (step && !decrypt)
         st_in = enc_r;
      else if (step)
         st_in = final_rnd ? dec_a : inv_mix(dec_a);
      else
         st_in = st_ff;
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign state = st_ff;
endmodule

// File: rtl/aes256_ecb_pkcs7_engine.sv
// AES-256 ECB engine with PKCS#7 padding: top level, sequencer and output register.
// Depends on aes_pkg, aes_key_sched and aes_round_unit.
//
// One 16-byte item in, one (two for a full final encrypt block) items out. The key is
// loaded through four 64-bit CSRs; each write restarts key expansion in the next cycle,
// one schedule word per cycle, during which no item is accepted. A block runs through
// the one shared round unit: a round key read in ST_PREP, then the initial key add plus
// fourteen rounds in ST_RUN, one per cycle, then ST_OUT hands the result to the output
// register; a new item is accepted only back in idle, and the extra all-padding block
// takes the same path again. The round key memory has a registered read port, which is
// why each round key is read in the cycle before its round. The result sits in an
// output register until taken; the next item may be accepted while it waits, and a
// finished block then holds in the round unit until the output register is free.
// Encrypt results always carry count 16 and no pad error. On a final decrypt block the
// last byte gives the pad; a pad of 0 or above 16 raises pad_error with count 16.
// An empty encrypt message (last, count 0, no earlier block) produces no result.
module aes256_ecb_pkcs7_engine #(
   parameter int BLOCK_BYTES = aes_pkg::BLOCK_BYTES,
   parameter int KEY_BITS    = aes_pkg::KEY_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [63:0]               req_in_high,
   input  logic [63:0]               req_in_low,
   input  logic [aes_pkg::CNT_W-1:0] req_in_count,
   input  logic                      req_in_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [63:0]               rsp_out_high,
   output logic [63:0]               rsp_out_low,
   output logic [aes_pkg::CNT_W-1:0] rsp_out_count,
   output logic                      rsp_out_last,
   output logic                      rsp_pad_error,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [63:0]               csr_data
);
   import aes_pkg::*;

   localparam int BB_W = $clog2(BLOCK_BYTES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                kick_ff;
   logic [2:0]          st_ff, st_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic                mode_ff, last_ff, pad2_ff, inmsg_ff;
   logic                mode_in, last_in, pad2_in, inmsg_in;
   logic                ov_ff, ov_in;
   logic [63:0]         oh_ff, ol_ff;
   logic [CNT_W-1:0]    oc_ff;
   logic                olast_ff, oerr_ff;
   logic                sched_busy;
   logic [RK_AW-1:0]    rk_addr;
   block_type           rk_data, st, din;
   logic                load, step, first, fin;
   block_type           blk_in;
   logic [BB_W-1:0]     cnt;
   logic                accept;

   // key register file; a write restarts expansion next cycle
   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY0: key_in[255:192] = csr_data;
            CSR_KEY1: key_in[191:128] = csr_data;
            CSR_KEY2: key_in[127:64]  = csr_data;
            CSR_KEY3: key_in[63:0]    = csr_data;
            default:  key_in = key_ff;
         endcase
      end
   end

   aes_key_sched u_sched (
      .clock   (clock),
      .reset   (reset),
      .start   (kick_ff),
      .key     (key_ff),
      .rd_addr (rk_addr),
      .rd_data (rk_data),
      .busy    (sched_busy)
   );

   aes_round_unit u_round (
      .clock     (clock),
      .load      (load),
      .step      (step),
      .decrypt   (mode_ff),
      .first     (first),
      .final_rnd (fin),
      .din       (din),
      .round_key (rk_data),
      .state     (st)
   );

   // a waiting result does not block the input; ST_OUT holds until the register frees
   assign req_ready = (st_ff == ST_IDLE) && !sched_busy && !kick_ff;
   assign accept    = req_valid && req_ready;

   // padded input block for short final encrypt blocks
   always_comb begin
      cnt = (req_in_count > CNT_W'(BLOCK_BYTES)) ? BB_W'(BLOCK_BYTES)
                                                 : req_in_count[BB_W-1:0];
      blk_in = {req_in_high, req_in_low};
      if (req_mode == MODE_ENC && req_in_last)
         for (int i = 0; i < BLOCK_BYTES; i++)
            if (BB_W'(i) >= cnt)
               blk_in[127 - 8*i -: 8] = 8'(BB_W'(BLOCK_BYTES) - cnt);
   end

   // round key row: encrypt walks 0..14, decrypt walks 14..0; read uses the next round
   logic [RND_W-1:0] krow;
   always_comb begin
      krow = (mode_ff == MODE_DEC) ? RND_W'(ROUNDS) - rnd_in : rnd_in;
      rk_addr = {krow, 1'b0};
   end

   assign first = (rnd_ff == '0);
   assign fin   = (rnd_ff == RND_W'(ROUNDS));
   assign step  = (st_ff == ST_RUN);

   always_comb begin
      st_in    = st_ff;
      rnd_in   = rnd_ff;
      mode_in  = mode_ff;
      last_in  = last_ff;
      pad2_in  = pad2_ff;
      inmsg_in = inmsg_ff;
      ov_in    = ov_ff && !rsp_ready;
      load     = 1'b0;
      din      = blk_in;
      unique case (st_ff)
         ST_IDLE: begin
            rnd_in = '0;
            if (accept) begin
               mode_in = req_mode;
               last_in = req_in_last;
               pad2_in = 1'b0;
               inmsg_in = !req_in_last;
               load = 1'b1;
               st_in = ST_PREP;
               if (req_mode == MODE_ENC && req_in_last) begin
                  if (cnt == '0) begin
                     din = {BLOCK_BYTES{8'(BLOCK_BYTES)}};
                     if (!inmsg_ff) st_in = ST_IDLE;
                  end else if (cnt == BB_W'(BLOCK_BYTES)) begin
                     pad2_in = 1'b1;
                     last_in = 1'b0;
                  end
               end
            end
         end
         ST_PREP: st_in = ST_RUN;
         ST_RUN: begin
            rnd_in = rnd_ff + 1'b1;
            if (fin) begin
               rnd_in = '0;
               st_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               st_in = pad2_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            load    = 1'b1;
            din     = {BLOCK_BYTES{8'(BLOCK_BYTES)}};
            pad2_in = 1'b0;
            last_in = 1'b1;
            st_in   = ST_PREP;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         rnd_ff   <= '0;
         inmsg_ff <= 1'b0;
         ov_ff    <= 1'b0;
         kick_ff  <= 1'b0;
         key_ff   <= '0;
         pad2_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         rnd_ff   <= rnd_in;
         inmsg_ff <= inmsg_in;
         ov_ff    <= ov_in;
         kick_ff  <= csr_write && (csr_index == CSR_KEY0 || csr_index == CSR_KEY1 ||
                                   csr_index == CSR_KEY2 || csr_index == CSR_KEY3);
         key_ff   <= key_in;
         pad2_ff  <= pad2_in;
      end
      mode_ff <= mode_in;
      last_ff <= last_in;
   end

   // output register, loaded when the finished block is handed over
   logic [7:0] pad_b;
   logic       bad;
   assign pad_b = st[7:0];
   assign bad   = (pad_b == 8'd0) || (pad_b > 8'(BLOCK_BYTES));

   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && (!ov_ff || rsp_ready)) begin
         oh_ff    <= st[127:64];
         ol_ff    <= st[63:0];
         olast_ff <= last_ff;
         if (mode_ff == MODE_DEC && last_ff) begin
            oerr_ff <= bad;
            oc_ff   <= bad ? CNT_W'(BLOCK_BYTES) : CNT_W'(BLOCK_BYTES) - CNT_W'(pad_b);
         end else begin
            oerr_ff <= 1'b0;
            oc_ff   <= CNT_W'(BLOCK_BYTES);
         end
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_out_high  = oh_ff;
   assign rsp_out_low   = ol_ff;
   assign rsp_out_count = oc_ff;
   assign rsp_out_last  = olast_ff;
   assign rsp_pad_error = oerr_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset)
         sched_busy |-> !req_ready;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept during key load");

   property p_run_round;
      @(posedge clock) disable iff (reset)
         st_ff == ST_RUN |-> rnd_ff <= RND_W'(ROUNDS);
   endproperty
   a_run_round: assert property (p_run_round) else $error("round overrun");

   property p_enc_clean;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_pad_error |-> rsp_out_last && rsp_out_count == CNT_W'(BLOCK_BYTES);
   endproperty
   a_enc_clean: assert property (p_enc_clean) else $error("pad error shape");

   property p_pad_follow;
      @(posedge clock) disable iff (reset)
         st_ff == ST_PAD |=> st_ff == ST_PREP;
   endproperty
   a_pad_follow: assert property (p_pad_follow) else $error("pad block start");
endmodule

// File: tb/tb_aes256_ecb_pkcs7_engine.sv
// Self-checking testbench for the AES-256 ECB engine with PKCS#7 padding.
// Depends on aes_pkg (CSR indexes, modes, count width) and the engine RTL.
module tb_aes256_ecb_pkcs7_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import aes_pkg::*;

   localparam int LIMIT  = 1000000;
   localparam int NITEMS = 1550;
   localparam int QUIET  = 1330;   // no idling on either side past this many items

   typedef struct {
      logic [63:0]      hi;
      logic [63:0]      lo;
      logic [CNT_W-1:0] cnt;
      logic             last;
      logic             err;
   } blk_result_type;

   // Scoreboard: keeps its own copy of the key schedule and the message flag,
   // predicts the result blocks of each accepted item and checks them in order.
   class block_board_type;
      logic [7:0]  fbox [256];
      logic [7:0]  ibox [256];
      logic [63:0] key_word [4];
      logic [31:0] sched [60];
      bit          open_msg;
      blk_result_type pending_blocks [$];
      int          errors;
      int          checked;
      int          pad_flags;

      function new();
         logic [7:0] v, b;
         for (int x = 0; x < 256; x++) begin
            v = 0;
            for (int y = 1; y < 256; y++)
               if (gmul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
            b = v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
            fbox[x] = b;
            ibox[b] = 8'(x);
         end
         for (int i = 0; i < 4; i++) key_word[i] = '0;
         open_msg = 0;
         errors = 0;
         checked = 0;
         pad_flags = 0;
      endfunction

      function logic [7:0] rol8(logic [7:0] a, int n);
         return (a << n) | (a >> (8 - n));
      endfunction

      function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
         logic [7:0] p;
         p = 0;
         for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
         end
         return p;
      endfunction

      function logic [31:0] subw(logic [31:0] w);
         return {fbox[w[31:24]], fbox[w[23:16]], fbox[w[15:8]], fbox[w[7:0]]};
      endfunction

      // any key word write re-expands the whole schedule
      function void set_key(int idx, logic [63:0] val);
         logic [31:0] t;
         logic [7:0]  rc;
         key_word[idx] = val;
         for (int i = 0; i < 8; i++)
            sched[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
         rc = 8'h01;
         for (int i = 8; i < 60; i++) begin
            t = sched[i - 1];
            if (i % 8 == 0) begin
               t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
               rc = gmul(rc, 8'h02);
            end else if (i % 8 == 4) begin
               t = subw(t);
            end
            sched[i] = sched[i - 8] ^ t;
         end
      endfunction

      function void add_rk(ref logic [7:0] s [16], input int r);
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               s[4*c + j] ^= sched[4*r + c][31 - 8*j -: 8];
      endfunction

      function void shift_sub(ref logic [7:0] s [16], input bit inv);
         logic [7:0] t [16];
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               if (inv) t[r + 4*((c + r) & 3)] = ibox[s[r + 4*c]];
               else t[r + 4*c] = fbox[s[r + 4*((c + r) & 3)]];
         s = t;
      endfunction

      function void mix(ref logic [7:0] s [16], input bit inv);
         logic [7:0] k0, k1, k2, k3, a0, a1, a2, a3;
         k0 = inv ? 14 : 2; k1 = inv ? 11 : 3; k2 = inv ? 13 : 1; k3 = inv ? 9 : 1;
         for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c + 1]; a2 = s[4*c + 2]; a3 = s[4*c + 3];
            s[4*c]     = gmul(a0, k0) ^ gmul(a1, k1) ^ gmul(a2, k2) ^ gmul(a3, k3);
            s[4*c + 1] = gmul(a0, k3) ^ gmul(a1, k0) ^ gmul(a2, k1) ^ gmul(a3, k2);
            s[4*c + 2] = gmul(a0, k2) ^ gmul(a1, k3) ^ gmul(a2, k0) ^ gmul(a3, k1);
            s[4*c + 3] = gmul(a0, k1) ^ gmul(a1, k2) ^ gmul(a2, k3) ^ gmul(a3, k0);
         end
      endfunction

      // one full AES-256 pass; byte 0 of the block sits in bits 127:120
      function logic [127:0] aes_block(logic [127:0] blk, bit inv);
         logic [7:0] s [16];
         logic [127:0] o;
         for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
         if (!inv) begin
            add_rk(s, 0);
            for (int r = 1; r < 14; r++) begin
               shift_sub(s, 0); mix(s, 0); add_rk(s, r);
            end
            shift_sub(s, 0); add_rk(s, 14);
         end else begin
            add_rk(s, 14);
            for (int r = 13; r > 0; r--) begin
               shift_sub(s, 1); add_rk(s, r); mix(s, 1);
            end
            shift_sub(s, 1); add_rk(s, 0);
         end
         for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
         return o;
      endfunction

      function void push_block(logic [127:0] b, int cnt, bit last, bit err);
         blk_result_type e;
         e.hi = b[127:64]; e.lo = b[63:0]; e.cnt = CNT_W'(cnt); e.last = last; e.err = err;
         pending_blocks.push_back(e);
      endfunction

      function void take_block(logic mode, logic [63:0] hi, logic [63:0] lo,
                               logic [CNT_W-1:0] cnt_in, logic last);
         logic [127:0] b, d;
         int cnt, pad;
         bit had;
         b = {hi, lo};
         cnt = (cnt_in > 16) ? 16 : cnt_in;
         if (mode == MODE_ENC) begin
            if (!last) begin
               push_block(aes_block(b, 0), 16, 0, 0);
               open_msg = 1;
            end else if (cnt == 0) begin
               // empty final item: pad block only if the message has blocks
               had = open_msg;
               open_msg = 0;
               if (had) push_block(aes_block({16{8'h10}}, 0), 16, 1, 0);
            end else if (cnt < 16) begin
               open_msg = 0;
               for (int i = cnt; i < 16; i++) b[127 - 8*i -: 8] = 8'(16 - cnt);
               push_block(aes_block(b, 0), 16, 1, 0);
            end else begin
               open_msg = 0;
               push_block(aes_block(b, 0), 16, 0, 0);
               push_block(aes_block({16{8'h10}}, 0), 16, 1, 0);
            end
         end else begin
            d = aes_block(b, 1);
            if (!last) begin
               push_block(d, 16, 0, 0);
               open_msg = 1;
            end else begin
               open_msg = 0;
               pad = d[7:0];
               if (pad == 0 || pad > 16) push_block(d, 16, 1, 1);
               else push_block(d, 16 - pad, 1, 0);
            end
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task match_block(blk_result_type got);
         blk_result_type e;
         if (pending_blocks.size() == 0) begin
            report($sformatf("unexpected result block %h_%h", got.hi, got.lo));
            return;
         end
         e = pending_blocks.pop_front();
         checked++;
         if (got.err) pad_flags++;
         if (got.hi !== e.hi) report($sformatf("out_high %h, want %h", got.hi, e.hi));
         if (got.lo !== e.lo) report($sformatf("out_low %h, want %h", got.lo, e.lo));
         if (got.cnt !== e.cnt) report($sformatf("out_count %0d, want %0d", got.cnt, e.cnt));
         if (got.last !== e.last) report($sformatf("out_last %b, want %b", got.last, e.last));
         if (got.err !== e.err) report($sformatf("pad_error %b, want %b", got.err, e.err));
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   logic             req_mode = MODE_ENC;
   logic [63:0]      req_in_high = '0;
   logic [63:0]      req_in_low = '0;
   logic [CNT_W-1:0] req_in_count = '0;
   logic             req_in_last = 0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   logic [63:0]      rsp_out_high;
   logic [63:0]      rsp_out_low;
   logic [CNT_W-1:0] rsp_out_count;
   logic             rsp_out_last;
   logic             rsp_pad_error;
   logic             csr_write = 0;
   logic [1:0]       csr_index = CSR_KEY0;
   logic [63:0]      csr_data = '0;

   block_board_type board = new();
   int  cycles = 0;
   int  sent = 0;
   int  msgs = 0;
   bit  quiet = 0;

   always #4 clock = ~clock;

   aes256_ecb_pkcs7_engine DUT (.*);

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d blocks still expected",
                  cycles, board.pending_blocks.size());
         $display("tb_aes256_ecb_pkcs7_engine: FAIL");
         $finish;
      end
   end

   // result monitor: values read here are the pre-edge ones
   always @(posedge clock) begin
      blk_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.hi = rsp_out_high; got.lo = rsp_out_low; got.cnt = rsp_out_count;
         got.last = rsp_out_last; got.err = rsp_pad_error;
         board.match_block(got);
      end
   end

   // receiver: random stall bursts, one long hold-off once more than 200 items are sent
   // so the input side backs up, then always ready near the end
   initial begin
      bit held;
      int hold;
      held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && sent > 200) begin
            held = 1;
            rsp_ready <= 0;
            hold = 0;
            while (hold < 400) begin
               @(posedge clock);
               hold++;
            end
            rsp_ready <= 1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // present one item and hold it until taken; gap only lowers valid when idling follows
   task send_item(logic mode, logic [63:0] hi, logic [63:0] lo, int cnt, logic last);
      int gap;
      req_valid <= 1; req_mode <= mode; req_in_high <= hi; req_in_low <= lo;
      req_in_count <= CNT_W'(cnt); req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      board.take_block(mode, hi, lo, CNT_W'(cnt), last);
      sent++;
      if (sent >= QUIET) quiet = 1;
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // key writes only with the engine drained; extra cycles cover empty items
   task write_key(int idx, logic [63:0] val);
      req_valid <= 0;
      while (board.pending_blocks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write <= 1; csr_index <= 2'(idx); csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      board.set_key(idx, val);
   endtask

   task load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
      write_key(CSR_KEY0, k0);
      write_key(CSR_KEY1, k1);
      write_key(CSR_KEY2, k2);
      write_key(CSR_KEY3, k3);
   endtask

   function logic [63:0] r64();
      return {$urandom, $urandom};
   endfunction

   // ciphertext whose deciphered last byte is the given pad value
   function logic [127:0] cipher_with_pad(logic [7:0] pad);
      logic [127:0] p;
      p = {r64(), r64()};
      p[7:0] = pad;
      return board.aes_block(p, 0);
   endfunction

   // one random message: mostly well-formed with random content, some noise
   task random_message();
      int nblk, cnt, sel;
      logic mode;
      logic [127:0] c;
      sel = $urandom_range(0, 9);
      mode = $urandom_range(0, 1);
      msgs++;
      if (sel == 0) begin
         send_item($urandom_range(0, 1), r64(), r64(), $urandom_range(0, 31),
                   $urandom_range(0, 1));
         return;
      end
      nblk = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
      for (int i = 0; i < nblk; i++) begin
         cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 16;
         send_item(mode, r64(), r64(), cnt, 0);
      end
      if (mode == MODE_ENC) begin
         case ($urandom_range(0, 3))
            0: cnt = 16;
            1: cnt = 0;
            default: cnt = $urandom_range(0, 31);
         endcase
         send_item(MODE_ENC, r64(), r64(), cnt, 1);
      end else begin
         c = (sel < 8) ? cipher_with_pad($urandom_range(1, 16)) : {r64(), r64()};
         send_item(MODE_DEC, c[127:64], c[63:0], $urandom_range(0, 31), 1);
      end
   endtask

   initial begin
      logic [127:0] c;
      repeat (5) @(posedge clock);
      reset <= 0;
      load_key(r64(), r64(), r64(), r64());

      // directed: empty message, short/full/oversize final blocks
      send_item(MODE_ENC, r64(), r64(), 0, 1);
      send_item(MODE_ENC, '0, '0, 1, 1);
      send_item(MODE_ENC, '1, '1, 15, 1);
      send_item(MODE_ENC, r64(), r64(), 16, 1);
      send_item(MODE_ENC, r64(), r64(), 31, 1);
      // short non-final block, then empty final item gives a pad-only block
      send_item(MODE_ENC, r64(), r64(), 5, 0);
      send_item(MODE_ENC, r64(), r64(), 0, 1);
      // decrypt: non-final, good pads at both ends, pad 0, pad 17, pad 255
      send_item(MODE_DEC, '1, '0, 0, 0);
      c = cipher_with_pad(8'd1);  send_item(MODE_DEC, c[127:64], c[63:0], 16, 1);
      c = cipher_with_pad(8'd16); send_item(MODE_DEC, c[127:64], c[63:0], 3, 1);
      c = cipher_with_pad(8'd0);  send_item(MODE_DEC, c[127:64], c[63:0], 16, 1);
      c = cipher_with_pad(8'd17); send_item(MODE_DEC, c[127:64], c[63:0], 0, 1);
      c = cipher_with_pad(8'hff); send_item(MODE_DEC, c[127:64], c[63:0], 31, 1);
      // mode change mid-message both ways
      send_item(MODE_ENC, r64(), r64(), 16, 0);
      send_item(MODE_DEC, r64(), r64(), 16, 1);
      send_item(MODE_ENC, r64(), r64(), 0, 1);
      send_item(MODE_DEC, r64(), r64(), 16, 0);
      send_item(MODE_ENC, r64(), r64(), 0, 1);

      while (sent < 450) random_message();
      load_key('0, '0, '0, '0);
      send_item(MODE_ENC, '0, '0, 16, 1);
      while (sent < 800) random_message();
      load_key('1, '1, '1, '1);
      send_item(MODE_ENC, '1, '1, 16, 1);
      while (sent < 1100) random_message();
      write_key(CSR_KEY2, r64());
      while (sent < NITEMS) random_message();
      req_valid <= 0;

      while (board.pending_blocks.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d items in %0d random messages plus directed cases, %0d result blocks",
               sent, msgs, board.checked);
      $display("key settings: random, all zero, all one, partial rewrite; %0d pad errors seen",
               board.pad_flags);
      if (board.errors == 0 && board.pending_blocks.size() == 0)
         $display("tb_aes256_ecb_pkcs7_engine: PASS");
      else
         $display("tb_aes256_ecb_pkcs7_engine: FAIL");
      $finish;
   end
endmodule
